FILE: sv/wbps_pkg.sv
// Shared types and constants of the wildcard byte pattern scanner.
package wbps_pkg;

    localparam int DATA_W            = 8;
    localparam int ADDR_W            = 48;
    localparam int CFG_PATTERN_BYTES = 16;
    localparam int PAT_IDX_W         = 4;
    localparam int LEN_W             = 5;
    localparam int MASK_W            = 16;
    localparam int CFG_IDX_W         = 8;
    localparam int CFG_DATA_W        = 64;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 8'd3;

    localparam logic [LEN_W-1:0] LENGTH_RESET = 5'd1;

    typedef logic [DATA_W-1:0] t_byte;
    typedef logic [ADDR_W-1:0] t_addr;

    // Per-cell compare control, derived from the pattern length and the wildcard mask.
    typedef struct packed {
        logic in_use;
        logic wild;
        logic tail;
    } t_cell_ctl;

    typedef struct packed {
        logic  match_found;
        t_addr match_address;
    } t_result;

endpackage

FILE: sv/wbps_ifs.sv
// Handshake channels of the scanner: input bytes, results and register writes.
interface wbps_in_if import wbps_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte data_byte;
    t_addr byte_address;
    logic  region_start;

    modport source (output valid, data_byte, byte_address, region_start, input ready);
    modport sink   (input valid, data_byte, byte_address, region_start, output ready);
endinterface

interface wbps_out_if import wbps_pkg::*; ();
    logic  valid;
    logic  ready;
    logic  match_found;
    t_addr match_address;

    modport source (output valid, match_found, match_address, input ready);
    modport sink   (input valid, match_found, match_address, output ready);
endinterface

interface wbps_cfg_if import wbps_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/wbps_cell.sv
// One window cell: holds a byte and its valid flag, compares the incoming byte.
module wbps_cell import wbps_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_shift,
    input  logic      i_clear,
    input  t_byte     i_prev_byte,
    input  logic      i_prev_valid,
    input  t_byte     i_pat_byte,
    input  t_cell_ctl i_ctl,
    output t_byte     o_byte,
    output logic      o_valid,
    output logic      o_ok
);

    t_byte r_byte;
    t_byte n_byte;
    logic  r_valid;
    logic  n_valid;

    // A new region empties the cell before the shift lands.
    always_comb begin
        n_byte  = i_clear ? '0 : i_prev_byte;
        n_valid = i_clear ? 1'b0 : i_prev_valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_byte <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_shift) begin
            r_valid <= n_valid;
        end
    end

    // The tail cell also proves the region holds enough bytes.
    assign o_ok = !i_ctl.in_use
                | ((i_ctl.wild | (n_byte == i_pat_byte)) & (!i_ctl.tail | n_valid));

    assign o_byte  = r_byte;
    assign o_valid = r_valid;

endmodule

FILE: sv/wbps_out_buf.sv
// Two-entry output buffer: result register plus skid stage.
module wbps_out_buf import wbps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_result,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_result
);

    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    logic    r_skid_valid;
    logic    n_skid_valid;
    t_result r_skid;
    t_result n_skid;
    logic    w_take;

    assign w_take  = r_out_valid & i_ready;
    assign o_ready = !r_skid_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (w_take) begin
            if (r_skid_valid) begin
                // advance the parked beat
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_out_valid = i_valid;
                n_out       = i_result;
            end
        end else if (!r_out_valid) begin
            n_out_valid = i_valid;
            n_out       = i_result;
        end else if (i_valid && !r_skid_valid) begin
            // park the beat behind the stalled one
            n_skid_valid = 1'b1;
            n_skid       = i_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: sv/wildcard_byte_pattern_scanner_unit.sv
// Top level of the wildcard byte pattern scanner: config, cell chain, output buffer.
//
//  Channel    Dir  Beat contents
//  i_item     in   data_byte, byte_address, region_start
//  o_result   out  match_found, match_address
//  i_cfg      in   index (0 low bytes, 1 high bytes, 2 wildcard mask, 3 length), data
//
//  One byte is accepted per cycle unless i_item stalls; each result is registered.
//  The cell chain shifts and compares all window bytes in the accepting cycle.
//  Up to two results wait in the output buffer; i_item stalls only when both are held.
//  Reset empties the window and restores the registers (length 1, all else zero).
//  i_cfg is always ready; writes to unknown indexes are dropped.
module wildcard_byte_pattern_scanner_unit import wbps_pkg::*; #(
    parameter int MAX_PATTERN_BYTES = 16
) (
    input logic       i_clk,
    input logic       i_rst_n,
    wbps_in_if.sink   i_item,
    wbps_out_if.source o_result,
    wbps_cfg_if.sink  i_cfg
);

    localparam int PAT_CAP = (MAX_PATTERN_BYTES < CFG_PATTERN_BYTES) ?
                             MAX_PATTERN_BYTES : CFG_PATTERN_BYTES;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(PAT_CAP);

    logic [CFG_DATA_W-1:0] r_pat_low;
    logic [CFG_DATA_W-1:0] r_pat_high;
    logic [MASK_W-1:0]     r_wild;
    logic [LEN_W-1:0]      r_cfg_len;

    logic [LEN_W-1:0]                   w_len;
    logic [2*CFG_DATA_W-1:0]            w_pat_all;
    logic                               w_shift;
    logic                               w_in_ready;
    logic                               w_hit;
    t_result                            w_result;
    t_result                            w_out;
    t_byte     w_byte   [MAX_PATTERN_BYTES];
    logic      w_valid  [MAX_PATTERN_BYTES];
    logic      w_ok     [MAX_PATTERN_BYTES];
    t_byte     w_pat    [MAX_PATTERN_BYTES];
    t_cell_ctl w_ctl    [MAX_PATTERN_BYTES];
    logic [MAX_PATTERN_BYTES-1:0]       w_ok_vec;

    // Configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_wild     <= '0;
            r_cfg_len  <= LENGTH_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_PATTERN_LOW:  r_pat_low  <= i_cfg.data;
                REG_PATTERN_HIGH: r_pat_high <= i_cfg.data;
                REG_WILDCARD:     r_wild     <= i_cfg.data[MASK_W-1:0];
                REG_LENGTH:       r_cfg_len  <= i_cfg.data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_len     = (r_cfg_len > CAP_LEN) ? CAP_LEN : r_cfg_len;
    assign w_pat_all = {r_pat_high, r_pat_low};
    assign w_shift   = i_item.valid & w_in_ready;

    // Cell chain: cell j holds the byte j places back; it meets pattern byte len-1-j.
    for (genvar j = 0; j < MAX_PATTERN_BYTES; j++) begin : g_cell
        if (j < PAT_CAP) begin : g_cmp
            logic [LEN_W-1:0] w_k;
            assign w_k = w_len - LEN_W'(j) - LEN_W'(1);
            assign w_pat[j] = w_pat_all[{w_k[PAT_IDX_W-1:0], 3'b000} +: DATA_W];
            assign w_ctl[j].in_use = LEN_W'(j) < w_len;
            assign w_ctl[j].wild   = r_wild[w_k[PAT_IDX_W-1:0]];
            assign w_ctl[j].tail   = w_len == LEN_W'(j + 1);
        end else begin : g_idle
            assign w_pat[j] = '0;
            assign w_ctl[j] = '0;
        end

        if (j == 0) begin : g_head
            wbps_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_shift      (w_shift),
                .i_clear      (1'b0),
                .i_prev_byte  (i_item.data_byte),
                .i_prev_valid (1'b1),
                .i_pat_byte   (w_pat[j]),
                .i_ctl        (w_ctl[j]),
                .o_byte       (w_byte[j]),
                .o_valid      (w_valid[j]),
                .o_ok         (w_ok[j])
            );
        end else begin : g_body
            wbps_cell u_cell (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_shift      (w_shift),
                .i_clear      (i_item.region_start),
                .i_prev_byte  (w_byte[j-1]),
                .i_prev_valid (w_valid[j-1]),
                .i_pat_byte   (w_pat[j]),
                .i_ctl        (w_ctl[j]),
                .o_byte       (w_byte[j]),
                .o_valid      (w_valid[j]),
                .o_ok         (w_ok[j])
            );
        end

        assign w_ok_vec[j] = w_ok[j];
    end

    // A zero length leaves every cell idle; drop it explicitly.
    assign w_hit = (&w_ok_vec) & (w_len != '0);

    assign w_result.match_found   = w_hit;
    assign w_result.match_address = w_hit ?
        (i_item.byte_address - ADDR_W'(w_len - LEN_W'(1))) : '0;

    wbps_out_buf u_out_buf (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_item.valid),
        .o_ready  (w_in_ready),
        .i_result (w_result),
        .o_valid  (o_result.valid),
        .i_ready  (o_result.ready),
        .o_result (w_out)
    );

    assign i_item.ready           = w_in_ready;
    assign o_result.match_found   = w_out.match_found;
    assign o_result.match_address = w_out.match_address;

    // Checks
    a_no_match_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && !o_result.match_found |-> o_result.match_address == '0)
        else $error("nonzero address without a match");

    a_region_first_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift && i_item.region_start && (w_len > LEN_W'(1)) |-> !w_hit)
        else $error("multi-byte match on the first byte of a region");

    a_zero_len_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cfg_len == '0 |-> !w_hit)
        else $error("match with zero pattern length");

    a_skid_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_shift && o_result.valid && !o_result.ready |=> !i_item.ready)
        else $error("second waiting result not held in skid stage");

endmodule

FILE: dv/wbps_sb_pkg.sv
// Scoreboard for the wildcard byte pattern scanner: window/pattern predictor and result check.
`timescale 1ns / 1ps
package wbps_sb_pkg;
    import wbps_pkg::*;

    localparam int WINDOW_BYTES = 16;

    class match_scoreboard;
        t_byte         win [WINDOW_BYTES];
        int unsigned   fill;
        logic [63:0]   pat_lo;
        logic [63:0]   pat_hi;
        logic [15:0]   wild_mask;
        logic [4:0]    pat_len;
        t_result       expected_matches [$];
        int unsigned   failures;

        function new();
            foreach (win[i]) win[i] = '0;
            fill      = 0;
            pat_lo    = '0;
            pat_hi    = '0;
            wild_mask = '0;
            pat_len   = LENGTH_RESET;
            failures  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_PATTERN_LOW:  pat_lo = val;
                REG_PATTERN_HIGH: pat_hi = val;
                REG_WILDCARD:     wild_mask = val[MASK_W-1:0];
                REG_LENGTH:       pat_len = val[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Shift one byte into the window and queue the expected result it produces.
        function void take_byte(t_byte data, t_addr addr, logic first);
            int unsigned eff;
            bit          hit;
            t_byte       want;
            t_result     res;
            if (first) begin
                foreach (win[i]) win[i] = '0;
                fill = 0;
            end
            for (int i = WINDOW_BYTES - 1; i > 0; i--) win[i] = win[i-1];
            win[0] = data;
            if (fill < WINDOW_BYTES) fill++;
            eff = (pat_len > WINDOW_BYTES) ? WINDOW_BYTES : pat_len;
            hit = (eff != 0) && (fill >= eff);
            for (int k = 0; k < eff && hit; k++) begin
                want = (k < 8) ? pat_lo[k*8 +: 8] : pat_hi[(k-8)*8 +: 8];
                // pattern byte 0 lines up with the oldest byte of the match
                if (!wild_mask[k] && win[eff-1-k] != want) hit = 0;
            end
            res.match_found   = hit;
            res.match_address = hit ? addr - t_addr'(eff - 1) : '0;
            expected_matches = {expected_matches, res};
        endfunction

        function void check_match(logic found, t_addr addr);
            t_result want;
            if (expected_matches.size() == 0) begin
                $error("result beat with no byte outstanding: match_found %0b match_address %h",
                       found, addr);
                failures++;
                return;
            end
            want = expected_matches.pop_front();
            if (found !== want.match_found) begin
                $error("match_found expected %0b actual %0b", want.match_found, found);
                failures++;
            end
            if (addr !== want.match_address) begin
                $error("match_address expected %h actual %h", want.match_address, addr);
                failures++;
            end
        endfunction

        function int unsigned pending();
            return expected_matches.size();
        endfunction
    endclass

endpackage

FILE: dv/tb_top.sv
// Top-level testbench of the wildcard byte pattern scanner: stimulus, receiver and monitor.
`timescale 1ns / 1ps
module tb_top;
    import wbps_pkg::*;
    import wbps_sb_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n;

    wbps_in_if  item_if ();
    wbps_out_if res_if ();
    wbps_cfg_if cfg_if ();

    wildcard_byte_pattern_scanner_unit DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_if),
        .o_result (res_if),
        .i_cfg    (cfg_if)
    );

    match_scoreboard sb = new();

    bit          idle_on = 1'b1;
    int          hold_requests = 0;
    int unsigned bytes_sent = 0;

    // shadow of the loaded pattern, used to plant matches
    t_byte       plan_bytes [WINDOW_BYTES];
    logic [15:0] plan_wild;
    int unsigned plan_len;

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("wildcard_byte_pattern_scanner_unit verification failed");
        $finish;
    end

    // Observe every beat at the clock edge, before the block updates.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n) begin
                if (cfg_if.valid && cfg_if.ready)
                    sb.write_reg(cfg_if.index, cfg_if.data);
                if (item_if.valid && item_if.ready)
                    sb.take_byte(item_if.data_byte, item_if.byte_address, item_if.region_start);
                if (res_if.valid && res_if.ready)
                    sb.check_match(res_if.match_found, res_if.match_address);
            end
        end
    end

    // Result receiver: random stalls plus long hold-offs on request.
    initial begin
        int served;
        int hold_left;
        served    = 0;
        hold_left = 0;
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (served != hold_requests) begin
                served++;
                hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= !(idle_on && $urandom_range(0, 99) < 16);
            end
        end
    end

    task automatic send_byte(t_byte d, t_addr a, logic first);
        if (idle_on) begin
            while ($urandom_range(0, 99) < 16) begin
                item_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        item_if.valid        <= 1'b1;
        item_if.data_byte    <= d;
        item_if.byte_address <= a;
        item_if.region_start <= first;
        do @(posedge i_clk); while (!item_if.ready);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        item_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do @(posedge i_clk); while (!cfg_if.ready);
    endtask

    // Drain, then load all registers; junk bits above the wildcard and length fields must be dropped.
    task automatic load_pattern(logic [63:0] lo, logic [63:0] hi, logic [15:0] mask,
                                logic [4:0] len);
        logic [CFG_DATA_W-1:0] v;
        wait_drained();
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        v = {$urandom, $urandom};
        v[MASK_W-1:0] = mask;
        write_reg(REG_WILDCARD, v);
        v = {$urandom, $urandom};
        v[LEN_W-1:0] = len;
        write_reg(REG_LENGTH, v);
        // unknown index: must leave everything untouched
        write_reg(CFG_IDX_W'($urandom_range(REG_LENGTH + 1, (1 << CFG_IDX_W) - 1)),
                  {$urandom, $urandom});
        cfg_if.valid <= 1'b0;
        for (int k = 0; k < WINDOW_BYTES; k++)
            plan_bytes[k] = (k < 8) ? lo[k*8 +: 8] : hi[(k-8)*8 +: 8];
        plan_wild = mask;
        plan_len  = (len > WINDOW_BYTES) ? WINDOW_BYTES : len;
    endtask

    // One region: filler bytes with planted (sometimes truncated) pattern copies,
    // or a noise burst with scattered addresses and region starts.
    task automatic scan_region();
        t_addr       a;
        int unsigned n;
        int unsigned sent;
        int unsigned cut;
        bit          noise;
        logic        first;
        t_byte       b;
        noise = $urandom_range(0, 99) < 15;
        n     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : $urandom_range(16, 48);
        a     = t_addr'({$urandom, $urandom});
        first = 1'b1;
        sent  = 0;
        while (sent < n) begin
            if (!noise && plan_len > 0 && $urandom_range(0, 99) < 35) begin
                cut = ($urandom_range(0, 9) == 0) ? $urandom_range(1, plan_len) : plan_len;
                for (int k = 0; k < cut; k++) begin
                    b = plan_wild[k] ? t_byte'($urandom) : plan_bytes[k];
                    send_byte(b, a, first);
                    first = 1'b0;
                    a++;
                    sent++;
                end
            end else begin
                b = $urandom_range(0, 1) ? plan_bytes[$urandom_range(0, WINDOW_BYTES - 1)]
                                         : t_byte'($urandom);
                if (noise) begin
                    a     = t_addr'({$urandom, $urandom});
                    first = ($urandom_range(0, 7) == 0);
                end
                send_byte(b, a, first);
                first = 1'b0;
                a++;
                sent++;
            end
        end
    endtask

    initial begin
        logic [63:0] lo;
        logic [63:0] hi;
        logic [15:0] mask;
        logic [4:0]  len;
        t_byte       rep;
        int unsigned target;

        i_rst_n              = 1'b0;
        item_if.valid        = 1'b0;
        item_if.data_byte    = '0;
        item_if.byte_address = '0;
        item_if.region_start = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        for (int k = 0; k < WINDOW_BYTES; k++) plan_bytes[k] = '0;
        plan_wild = '0;
        plan_len  = 1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: single zero byte, no wildcards
        send_byte(8'h00, '0, 1'b1);
        send_byte(8'hFF, '1, 1'b0);
        send_byte(8'h00, '1, 1'b0);

        // AA, any, FF
        load_pattern(64'h0000_0000_00FF_5AAA, '1, 16'h0002, 5'd3);
        send_byte(8'hAA, t_addr'(0), 1'b1);
        send_byte(8'h00, t_addr'(1), 1'b0);
        send_byte(8'hFF, t_addr'(2), 1'b0);
        // match start wraps below zero
        send_byte(8'hAA, '1 - 1, 1'b1);
        send_byte(8'h12, '1, 1'b0);
        send_byte(8'hFF, t_addr'(0), 1'b0);
        // new region clears the window: no match from stale bytes
        send_byte(8'hAA, t_addr'(20), 1'b1);
        send_byte(8'h34, t_addr'(21), 1'b0);
        send_byte(8'hFF, t_addr'(22), 1'b1);
        send_byte(8'h00, t_addr'(23), 1'b0);
        // zero length never matches
        load_pattern(64'h0000_0000_00FF_5AAA, '1, 16'h0002, 5'd0);
        send_byte(8'hAA, t_addr'(0), 1'b1);
        send_byte(8'h77, t_addr'(1), 1'b0);
        send_byte(8'hFF, t_addr'(2), 1'b0);

        for (int ph = 0; ph < 12; ph++) begin
            lo   = {$urandom, $urandom};
            hi   = {$urandom, $urandom};
            mask = ($urandom_range(0, 1)) ? 16'($urandom) & 16'($urandom) : 16'($urandom);
            len  = ($urandom_range(0, 9) < 7) ? 5'($urandom_range(1, 16))
                                              : 5'($urandom_range(0, 31));
            if ($urandom_range(0, 3) == 0) begin
                // repeated byte: overlapping matches
                rep = t_byte'($urandom);
                lo  = {8{rep}};
                hi  = {8{rep}};
            end
            case (ph)
                0: begin len = 5'd16; mask = '0;  end
                1: begin len = 5'd16; mask = '1; lo = '0; hi = '0; end
                2: begin len = 5'd1;  mask = '0;  end
                3: len = 5'd0;
                4: begin len = 5'd31; lo = '1; hi = '1; end
                5: len = 5'd17;
                default: ;
            endcase
            load_pattern(lo, hi, mask, len);
            idle_on = (ph != 2);
            if (ph == 1 || $urandom_range(0, 3) == 0) hold_requests++;
            target = bytes_sent + 62;
            while (bytes_sent < target) scan_region();
        end

        idle_on = 1'b1;
        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("wildcard_byte_pattern_scanner_unit verification clean");
        else
            $display("wildcard_byte_pattern_scanner_unit verification failed");
        $finish;
    end

endmodule
